>>> hw/rtl/b64_pkg.sv
// Package: shared types, codes and alphabet functions for the base64 codec.
`timescale 1ns / 1ps

package b64_pkg;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    // Job queue depth between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // One job: up to four result bytes from a single input item
    typedef struct packed {
        logic [3:0][7:0] data;     // data[0] leaves first
        logic [1:0]      num_m1;   // number of bytes minus one
        logic            last;     // job closes the stream
        logic            err;      // single error result
    } job_t;

    // Front to queue handshake
    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)       return w + 8'h41;
        else if (v < 6'd52)  return w + 8'd71;
        else if (v < 6'd62)  return w - 8'd4;
        else if (v == 6'd62) return 8'h2B;
        else                 return 8'h2F;
    endfunction

    // Character to {invalid, value}; pad reads as zero
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h47)};
        else if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c + 8'd4)};
        else if (c == 8'h2B)               return 7'd62;
        else if (c == 8'h2F)               return 7'd63;
        else if (c == PAD_CHAR)            return 7'd0;
        else                               return 7'h40;
    endfunction

endpackage

>>> hw/rtl/b64_front.sv
// Front end: accepts items, tracks group state, builds result jobs.
`timescale 1ns / 1ps

module b64_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               stream_last,
    input  logic               q_full,
    output logic               in_stall,
    output b64_pkg::push_t     push_out
);

    logic        mode_reg, mode_next;
    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic        third_pad_reg, third_pad_next;
    logic        skip_reg, skip_next;

    logic        accept;
    logic [23:0] enc_bits;
    logic [23:0] enc_aligned;
    logic [2:0]  enc_cnt;
    logic [6:0]  sx;
    logic [23:0] dec_bits;
    logic        is_pad;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign enc_bits = {group_bits_reg[15:0], in_byte};
    assign enc_cnt  = {1'b0, group_count_reg} + 3'd1;
    assign sx       = b64_pkg::char_to_sextet(in_byte);
    assign dec_bits = {group_bits_reg[17:0], sx[5:0]};
    assign is_pad   = (in_byte == b64_pkg::PAD_CHAR);

    always_comb
    begin
        priority if (enc_cnt == 3'd1)
            enc_aligned = {enc_bits[7:0], 16'h0000};
        else if (enc_cnt == 3'd2)
            enc_aligned = {enc_bits[15:0], 8'h00};
        else
            enc_aligned = enc_bits;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        third_pad_next   = third_pad_reg;
        skip_next        = skip_reg;
        push_out         = '0;

        if (cfg_valid)
        begin
            // mode write restarts the stream
            mode_next        = cfg_data;
            group_bits_next  = '0;
            group_count_next = '0;
            third_pad_next   = 1'b0;
            skip_next        = 1'b0;
        end
        else if (accept)
        begin
            if (mode_reg == b64_pkg::MODE_ENCODE)
            begin
                if (enc_cnt < 3'd3 && !stream_last)
                begin
                    group_bits_next  = enc_bits;
                    group_count_next = enc_cnt[1:0];
                end
                else
                begin
                    push_out.push        = 1'b1;
                    push_out.job.data[0] = b64_pkg::sextet_to_char(enc_aligned[23:18]);
                    push_out.job.data[1] = b64_pkg::sextet_to_char(enc_aligned[17:12]);
                    push_out.job.data[2] = (enc_cnt < 3'd2) ? b64_pkg::PAD_CHAR
                                         : b64_pkg::sextet_to_char(enc_aligned[11:6]);
                    push_out.job.data[3] = (enc_cnt < 3'd3) ? b64_pkg::PAD_CHAR
                                         : b64_pkg::sextet_to_char(enc_aligned[5:0]);
                    push_out.job.num_m1  = 2'd3;
                    push_out.job.last    = stream_last;
                    group_bits_next      = '0;
                    group_count_next     = '0;
                    third_pad_next       = 1'b0;
                end
            end
            else
            begin
                if (skip_reg)
                begin
                    if (stream_last)
                    begin
                        skip_next        = 1'b0;
                        group_bits_next  = '0;
                        group_count_next = '0;
                        third_pad_next   = 1'b0;
                    end
                end
                else if (sx[6] || (group_count_reg != 2'd3 && stream_last))
                begin
                    // bad character or short final group
                    push_out.push       = 1'b1;
                    push_out.job.num_m1 = 2'd0;
                    push_out.job.last   = 1'b1;
                    push_out.job.err    = 1'b1;
                    group_bits_next     = '0;
                    group_count_next    = '0;
                    third_pad_next      = 1'b0;
                    skip_next           = sx[6] && !stream_last;
                end
                else if (group_count_reg != 2'd3)
                begin
                    group_bits_next  = dec_bits;
                    group_count_next = group_count_reg + 2'd1;
                    if (group_count_reg == 2'd2)
                        third_pad_next = is_pad;
                end
                else
                begin
                    push_out.push        = 1'b1;
                    push_out.job.data[0] = dec_bits[23:16];
                    push_out.job.data[1] = dec_bits[15:8];
                    push_out.job.data[2] = dec_bits[7:0];
                    push_out.job.num_m1  = third_pad_reg ? 2'd0 : (is_pad ? 2'd1 : 2'd2);
                    push_out.job.last    = stream_last;
                    group_bits_next      = '0;
                    group_count_next     = '0;
                    third_pad_next       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= b64_pkg::MODE_ENCODE;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            third_pad_reg   <= 1'b0;
            skip_reg        <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            third_pad_reg   <= third_pad_next;
            skip_reg        <= skip_next;
        end
    end

endmodule

>>> hw/rtl/b64_queue.sv
// Job queue: small FIFO between front end and output sequencer.
`timescale 1ns / 1ps

module b64_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  b64_pkg::push_t push_in,
    input  logic           pop,
    output b64_pkg::job_t  head,
    output logic           head_valid,
    output logic           full
);

    localparam logic [b64_pkg::Q_CNT_W-1:0] DEPTH_C = b64_pkg::Q_CNT_W'(b64_pkg::Q_DEPTH);
    localparam logic [b64_pkg::Q_PTR_W-1:0] LAST_C  = b64_pkg::Q_PTR_W'(b64_pkg::Q_DEPTH - 1);

    b64_pkg::job_t                mem_reg [b64_pkg::Q_DEPTH];
    logic [b64_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [b64_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [b64_pkg::Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = (cnt_reg == DEPTH_C);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push_in.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + b64_pkg::Q_CNT_W'(do_push) - b64_pkg::Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_in.job;
    end

endmodule

>>> hw/rtl/b64_back.sv
// Back end: walks each job and sends one result byte per cycle while out_stall is low.
`timescale 1ns / 1ps

module b64_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  b64_pkg::job_t head,
    input  logic          head_valid,
    output logic          pop,
    input  logic          out_stall,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          stream_end,
    output logic          error
);

    b64_pkg::job_t cur_job_reg, cur_job_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          run_last_reg, run_last_next;
    logic          stream_end_reg, stream_end_next;
    logic          error_reg, error_next;

    logic          advance;
    logic          at_end;
    logic          cur_done;

    assign advance  = !out_valid_reg || !out_stall;
    assign at_end   = (idx_reg == cur_job_reg.num_m1);
    assign cur_done = cur_valid_reg && advance && at_end;
    assign pop      = head_valid && (!cur_valid_reg || cur_done);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        stream_end_next = stream_end_reg;
        error_next      = error_reg;
        if (advance)
        begin
            out_valid_next  = cur_valid_reg;
            out_byte_next   = cur_job_reg.err ? 8'h00 : cur_job_reg.data[idx_reg];
            run_last_next   = at_end;
            stream_end_next = at_end && cur_job_reg.last;
            error_next      = cur_job_reg.err;
        end
    end

    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_job_next   = head;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (cur_done)
            cur_valid_next = 1'b0;
        else if (cur_valid_reg && advance)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg    <= cur_job_next;
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        stream_end_reg <= stream_end_next;
        error_reg      <= error_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;
    assign error      = error_reg;

endmodule

>>> hw/rtl/base64_codec_core.sv
// Top level: streaming base64 encoder/decoder with mode register.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (mode: 0 encode, 1 decode)
//  in      | in        | in_valid / in_stall   | in_byte, stream_last
//  out     | out       | out_valid / out_stall | out_byte, run_last, stream_end, error
//
//  One input transfer per cycle while the job queue has room; the front end
//  turns each item into zero to four result bytes in the same cycle.
//  Results leave one byte per cycle from the output register while out_stall
//  is low, so the single output port sets the rate: encode emits 4 bytes per 3 input bytes.
//  out_valid rises once the input transfer that causes it has passed the
//  queue entry, the current-job register and the output register.
//  Reset brings mode to encode with an empty group; no clearing pass.
//  out_stall only backs up the queue; in_stall rises when the queue is full.

module base64_codec_core
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       stream_last,
    // results
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       stream_end,
    output logic       error
);

    b64_pkg::push_t push;     // front -> queue
    b64_pkg::job_t  head;     // queue -> back
    logic           head_valid;
    logic           pop;
    logic           q_full;

    // the user must write the mode only while idle; the block does not enforce it, and the port is always ready
    assign cfg_ready = 1'b1;

    b64_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .stream_last (stream_last),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .push_out    (push)
    );

    b64_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_in    (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    b64_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .error      (error)
    );

`ifndef SYNTHESIS
    // error result is always a lone zero byte that closes the stream
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> run_last && stream_end && out_byte == 8'h00)
        else $error("error result malformed");

    // end of stream is always the last byte of its item
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream_end without run_last");

    // front must never push a job into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !q_full)
        else $error("job queue overflow");

    // a popped job must exist
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job queue underflow");
`endif

endmodule

>>> sim/base64_codec_core_tb.sv
// Testbench for base64_codec_core: random and directed streams checked by a scoreboard.
`timescale 1ns / 1ps

module base64_codec_core_tb;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;     // idle cycles before a mode write and before the final check
    localparam int HOLD_CYCLES   = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
        logic       err;
    } b64_result_t;

    // Tracks codec state and the results still owed by the block.
    class b64_scoreboard;
        logic        cur_mode;
        logic [23:0] acc_bits;
        logic [1:0]  acc_count;
        logic        pad_third;
        logic        dropping;
        b64_result_t due_results[$];
        int          errors;

        function void clear_group();
            acc_bits  = '0;
            acc_count = '0;
            pad_third = 1'b0;
        endfunction

        function new();
            cur_mode = b64_pkg::MODE_ENCODE;
            clear_group();
            dropping = 1'b0;
            errors   = 0;
        endfunction

        // A mode write restarts the stream in either direction.
        function void set_mode(logic m);
            cur_mode = m;
            clear_group();
            dropping = 1'b0;
        endfunction

        // Alphabet value of a character, pad reads as zero, -1 when invalid
        function int sextet_of(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
            if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
            if (c == 8'h2B) return 62;
            if (c == 8'h2F) return 63;
            if (c == b64_pkg::PAD_CHAR) return 0;
            return -1;
        endfunction

        function void owe(logic [7:0] d, logic rl, logic se, logic er);
            b64_result_t r;
            r.data       = d;
            r.run_last   = rl;
            r.stream_end = se;
            r.err        = er;
            due_results.push_back(r);
        endfunction

        function void encode_byte(logic [7:0] b, logic last);
            logic [23:0] bits;
            int          cnt;
            logic [7:0]  ch[4];
            bits = {acc_bits[15:0], b};
            cnt  = int'(acc_count) + 1;
            if (cnt < 3 && !last) begin
                acc_bits  = bits;
                acc_count = 2'(cnt);
                return;
            end
            if (cnt == 1) bits = bits << 16;
            else if (cnt == 2) bits = bits << 8;
            ch[0] = ALPHABET[bits[23:18]];
            ch[1] = ALPHABET[bits[17:12]];
            ch[2] = (cnt < 2) ? b64_pkg::PAD_CHAR : ALPHABET[bits[11:6]];
            ch[3] = (cnt < 3) ? b64_pkg::PAD_CHAR : ALPHABET[bits[5:0]];
            for (int k = 0; k < 4; k++)
                owe(ch[k], k == 3, last && k == 3, 1'b0);
            clear_group();
        endfunction

        function void decode_char(logic [7:0] c, logic last);
            int          v;
            int          nbytes;
            logic [23:0] bits;
            if (dropping) begin
                if (last) begin
                    dropping = 1'b0;
                    clear_group();
                end
                return;
            end
            v = sextet_of(c);
            if (v < 0) begin
                owe(8'h00, 1'b1, 1'b1, 1'b1);
                clear_group();
                dropping = !last;
                return;
            end
            bits = {acc_bits[17:0], 6'(v)};
            if (acc_count == 2'd2) pad_third = (c == b64_pkg::PAD_CHAR);
            if (acc_count < 2'd3) begin
                if (last) begin
                    // stream ends inside a group
                    owe(8'h00, 1'b1, 1'b1, 1'b1);
                    clear_group();
                end else begin
                    acc_bits  = bits;
                    acc_count = acc_count + 2'd1;
                end
                return;
            end
            nbytes = pad_third ? 1 : ((c == b64_pkg::PAD_CHAR) ? 2 : 3);
            for (int k = 0; k < nbytes; k++)
                owe(bits[23 - 8 * k -: 8], k == nbytes - 1, last && k == nbytes - 1, 1'b0);
            clear_group();
        endfunction

        function void transcode_item(logic [7:0] b, logic last);
            if (cur_mode == b64_pkg::MODE_DECODE) decode_char(b, last);
            else encode_byte(b, last);
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] d, logic rl, logic se, logic er);
            b64_result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result %02h with none outstanding", d));
                return;
            end
            want = due_results.pop_front();
            if (d !== want.data)
                report($sformatf("out_byte %02h, want %02h", d, want.data));
            if (rl !== want.run_last)
                report($sformatf("run_last %b, want %b", rl, want.run_last));
            if (se !== want.stream_end)
                report($sformatf("stream_end %b, want %b", se, want.stream_end));
            if (er !== want.err)
                report($sformatf("error %b, want %b", er, want.err));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       stream_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       error;

    b64_scoreboard sb;
    int   idle_pct = 36;
    int   sent = 0;
    int   cycles = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;

    base64_codec_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .stream_last(stream_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .error      (error)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("base64_codec_core_tb failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_byte, run_last, stream_end, error);
    end

    // One input transfer; returns just after the accepting edge.
    task send_item(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            in_byte  = 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid    = 1'b1;
        in_byte     = b;
        stream_last = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.transcode_item(b, last);
        sent++;
    endtask

    task wait_results;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
    endtask

    task write_mode(input logic m);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_mode(m);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task encode_stream(input int n);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom_range(255)), i == n - 1);
    endtask

    // Mostly well-formed text; the rest short, broken or noisy streams
    task decode_stream;
        int         kind;
        int         groups;
        int         tail;
        int         idx;
        logic [7:0] c;
        logic [7:0] chars[$];
        kind   = $urandom_range(9);
        groups = $urandom_range(1, 4);
        for (int i = 0; i < 4 * groups; i++)
            chars.push_back(ALPHABET[$urandom_range(63)]);
        tail = $urandom_range(2);
        if (tail >= 1) chars[chars.size() - 1] = b64_pkg::PAD_CHAR;
        if (tail == 2) chars[chars.size() - 2] = b64_pkg::PAD_CHAR;
        if (kind == 7)
        begin
            repeat ($urandom_range(1, 3)) void'(chars.pop_back());
        end
        else if (kind == 8)
        begin
            do c = 8'($urandom_range(255)); while (sb.sextet_of(c) >= 0);
            idx = $urandom_range(chars.size() - 1);
            chars[idx] = c;
        end
        else if (kind == 9)
        begin
            foreach (chars[i])
                if ($urandom_range(3) == 0) chars[i] = 8'($urandom_range(255));
                else if ($urandom_range(4) == 0) chars[i] = b64_pkg::PAD_CHAR;
        end
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1);
    endtask

    initial
    begin
        int   target;
        logic held;
        logic paused;
        sb     = new();
        held   = 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // encode: lone zero, two-byte flush, full group then one-byte flush
        write_mode(b64_pkg::MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b0);
        send_item(8'h41, 1'b1);

        // decode: one-byte group, full group, bad length, invalid then drop,
        // invalid on the last item, two-byte group
        write_mode(b64_pkg::MODE_DECODE);
        send_item(8'h51, 1'b0);
        send_item(8'h51, 1'b0);
        send_item(b64_pkg::PAD_CHAR, 1'b0);
        send_item(b64_pkg::PAD_CHAR, 1'b1);
        send_item(8'h2B, 1'b0);
        send_item(8'h2F, 1'b0);
        send_item(8'h39, 1'b0);
        send_item(8'h7A, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'h51, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h49, 1'b0);
        send_item(b64_pkg::PAD_CHAR, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode((ph % 2 == 1) ? b64_pkg::MODE_DECODE : b64_pkg::MODE_ENCODE);
            target = sent + 52;
            if (ph == 2) idle_pct = 0;
            while (sent < target)
            begin
                // result side holds off while input keeps coming
                if (ph == 1 && !held && sent > target - 45)
                begin
                    hold_request = 1'b1;
                    held = 1'b1;
                end
                if (ph == 3 && !paused && sent > target - 30)
                begin
                    wait_results();
                    paused = 1'b1;
                end
                if (sb.cur_mode == b64_pkg::MODE_DECODE) decode_stream();
                else encode_stream($urandom_range(1, 9));
            end
            idle_pct = 36;
            // leave the stream open so the mode write has to restart it
            if ($urandom_range(1) == 1)
                send_item(8'($urandom_range(255)), 1'b0);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
        if (sb.errors == 0)
            $display("base64_codec_core_tb passed");
        else
            $display("base64_codec_core_tb failed");
        $finish;
    end

endmodule
